// ===== rtl/assert_macros.svh =====
// Assertion macros for the checker file of the project.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, switched off while reset is held.
`define ASSERT_RST(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent check that also holds across reset.
`define ASSERT_ANY(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/dlrws_pkg.sv =====
// Shared constants and types for the dual-controller rectangle write sequencer.
// No dependencies.
package dlrws_pkg;

    localparam int unsigned COL_W  = 9;
    localparam int unsigned PAGE_W = 4;
    localparam int unsigned IDX_W  = 3;
    localparam int unsigned STEP_W = 5;

    localparam logic [COL_W-1:0] SPLIT_COLUMN = 9'd240;
    localparam logic [COL_W-1:0] SEG_OFFSET   = 9'd16;
    localparam logic [7:0]       PAGE_OFFSET  = 8'd9;

    // Controller byte codes
    localparam logic [7:0] CMD_SEL_LEFT  = 8'h6E;
    localparam logic [7:0] CMD_SEL_RIGHT = 8'h6F;
    localparam logic [7:0] CMD_PAGE_SET  = 8'h75;
    localparam logic [7:0] PAR_PAGE_END  = 8'h14;
    localparam logic [7:0] CMD_COL_SET   = 8'h15;
    localparam logic [7:0] PAR_COL_END   = 8'hFF;
    localparam logic [7:0] CMD_WRITE     = 8'h5C;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_START_COLUMN = 3'd0;
    localparam logic [IDX_W-1:0] REG_END_COLUMN   = 3'd1;
    localparam logic [IDX_W-1:0] REG_START_PAGE   = 3'd2;
    localparam logic [IDX_W-1:0] REG_END_PAGE     = 3'd3;
    localparam logic [IDX_W-1:0] REG_INVERT       = 3'd4;

    localparam logic [COL_W-1:0]  RST_START_COLUMN = 9'd0;
    localparam logic [COL_W-1:0]  RST_END_COLUMN   = 9'd479;
    localparam logic [PAGE_W-1:0] RST_START_PAGE   = 4'd0;
    localparam logic [PAGE_W-1:0] RST_END_PAGE     = 4'd11;

    // Everything the byte emitter needs to know about one accepted input
    typedef struct packed {
        logic [7:0]        pix;
        logic              img_end;
        logic [COL_W-1:0]  col;
        logic [PAGE_W-1:0] page;
        logic [1:0]        n_addr;
    } plan_t;

endpackage

// ===== rtl/dlrws_tracker.sv =====
// Configuration registers and column/page position tracking.
// Depends on dlrws_pkg.
module dlrws_tracker import dlrws_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [COL_W-1:0]  cfg_wdata,
    input  logic              accept,
    input  logic [7:0]        pixel_byte,
    output plan_t             plan
);

    logic [COL_W-1:0]  start_col_reg, start_col_next;
    logic [COL_W-1:0]  end_col_reg, end_col_next;
    logic [PAGE_W-1:0] start_page_reg, start_page_next;
    logic [PAGE_W-1:0] end_page_reg, end_page_next;
    logic              invert_reg, invert_next;
    logic [COL_W-1:0]  cur_col_reg, cur_col_next;
    logic [PAGE_W-1:0] cur_page_reg, cur_page_next;
    logic              geo_wr;
    logic              row_end;
    logic              img_end;

    always_comb begin
        start_col_next  = start_col_reg;
        end_col_next    = end_col_reg;
        start_page_next = start_page_reg;
        end_page_next   = end_page_reg;
        invert_next     = invert_reg;
        geo_wr          = 1'b0;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_START_COLUMN: begin
                    start_col_next = cfg_wdata;
                    geo_wr = 1'b1;
                end
                REG_END_COLUMN: begin
                    end_col_next = cfg_wdata;
                    geo_wr = 1'b1;
                end
                REG_START_PAGE: begin
                    start_page_next = cfg_wdata[PAGE_W-1:0];
                    geo_wr = 1'b1;
                end
                REG_END_PAGE: begin
                    end_page_next = cfg_wdata[PAGE_W-1:0];
                    geo_wr = 1'b1;
                end
                REG_INVERT: begin
                    invert_next = cfg_wdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    assign row_end = cur_col_reg >= end_col_reg;
    assign img_end = row_end && (cur_page_reg >= end_page_reg);

    always_comb begin
        cur_col_next  = cur_col_reg;
        cur_page_next = cur_page_reg;
        if (geo_wr) begin
            cur_col_next  = start_col_next;
            cur_page_next = start_page_next;
        end else if (accept) begin
            if (img_end) begin
                cur_col_next  = start_col_reg;
                cur_page_next = start_page_reg;
            end else if (row_end) begin
                cur_col_next  = start_col_reg;
                cur_page_next = cur_page_reg + 4'd1;
            end else begin
                cur_col_next = cur_col_reg + 9'd1;
            end
        end
    end

    // Row start and split column may both fire: two address runs
    always_comb begin
        plan.pix     = invert_reg ? ~pixel_byte : pixel_byte;
        plan.img_end = img_end;
        plan.col     = cur_col_reg;
        plan.page    = cur_page_reg;
        plan.n_addr  = {1'b0, cur_col_reg == start_col_reg}
                     + {1'b0, cur_col_reg == SPLIT_COLUMN};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_col_reg  <= RST_START_COLUMN;
            end_col_reg    <= RST_END_COLUMN;
            start_page_reg <= RST_START_PAGE;
            end_page_reg   <= RST_END_PAGE;
            invert_reg     <= 1'b0;
            cur_col_reg    <= RST_START_COLUMN;
            cur_page_reg   <= RST_START_PAGE;
        end else begin
            start_col_reg  <= start_col_next;
            end_col_reg    <= end_col_next;
            start_page_reg <= start_page_next;
            end_page_reg   <= end_page_next;
            invert_reg     <= invert_next;
            cur_col_reg    <= cur_col_next;
            cur_page_reg   <= cur_page_next;
        end
    end

endmodule

// ===== rtl/dlrws_emitter.sv =====
// Job register and byte sequencer with output register: turns one plan into
// zero, one or two addressing runs followed by the data byte. Depends on dlrws_pkg.
module dlrws_emitter import dlrws_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        accept,
    input  plan_t       plan,
    output logic        in_ready,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_bus_byte,
    output logic        m_is_data,
    output logic        m_last_of_run,
    output logic        m_image_done
);

    localparam logic [2:0] SEQ_SELECT   = 3'd0;
    localparam logic [2:0] SEQ_PAGE_CMD = 3'd1;
    localparam logic [2:0] SEQ_PAGE_LO  = 3'd2;
    localparam logic [2:0] SEQ_PAGE_HI  = 3'd3;
    localparam logic [2:0] SEQ_COL_CMD  = 3'd4;
    localparam logic [2:0] SEQ_COL_LO   = 3'd5;
    localparam logic [2:0] SEQ_COL_HI   = 3'd6;
    localparam logic [2:0] SEQ_WRITE    = 3'd7;

    plan_t             job_reg;
    logic              job_valid_reg, job_valid_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        byte_reg;
    logic              data_reg, last_reg, done_reg;

    logic              out_load;
    logic              job_last;
    logic              left;
    logic [COL_W-1:0]  col_off;
    logic [7:0]        cur_byte;
    logic              cur_data;

    assign out_load = job_valid_reg && (!out_valid_reg || m_ready);
    assign job_last = (step_reg[4:3] == job_reg.n_addr) && (step_reg[2:0] == 3'd0);
    assign in_ready = !job_valid_reg || (out_load && job_last);

    assign left    = job_reg.col < SPLIT_COLUMN;
    assign col_off = left ? (job_reg.col + SEG_OFFSET)
                          : (job_reg.col - SPLIT_COLUMN + SEG_OFFSET);

    always_comb begin
        cur_byte = job_reg.pix;
        cur_data = 1'b1;
        if (!job_last) begin
            case (step_reg[2:0])
                SEQ_SELECT: begin
                    cur_byte = left ? CMD_SEL_LEFT : CMD_SEL_RIGHT;
                    cur_data = 1'b0;
                end
                SEQ_PAGE_CMD: begin
                    cur_byte = CMD_PAGE_SET;
                    cur_data = 1'b0;
                end
                SEQ_PAGE_LO: cur_byte = {4'd0, job_reg.page} + PAGE_OFFSET;
                SEQ_PAGE_HI: cur_byte = PAR_PAGE_END;
                SEQ_COL_CMD: begin
                    cur_byte = CMD_COL_SET;
                    cur_data = 1'b0;
                end
                SEQ_COL_LO:  cur_byte = col_off[7:0];
                SEQ_COL_HI:  cur_byte = PAR_COL_END;
                SEQ_WRITE: begin
                    cur_byte = CMD_WRITE;
                    cur_data = 1'b0;
                end
                default: begin
                    cur_byte = job_reg.pix;
                    cur_data = 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        job_valid_next = job_valid_reg;
        step_next      = step_reg;
        if (accept) begin
            job_valid_next = 1'b1;
            step_next      = '0;
        end else if (out_load) begin
            if (job_last) begin
                job_valid_next = 1'b0;
            end else begin
                step_next = step_reg + 5'd1;
            end
        end
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            job_valid_reg <= job_valid_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: no reset
    always_ff @(posedge aclk) begin
        if (accept) begin
            job_reg <= plan;
        end
        if (out_load) begin
            byte_reg <= cur_byte;
            data_reg <= cur_data;
            last_reg <= job_last;
            done_reg <= job_last && job_reg.img_end;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_bus_byte    = byte_reg;
    assign m_is_data     = data_reg;
    assign m_last_of_run = last_reg;
    assign m_image_done  = done_reg;

endmodule

// ===== rtl/dual_lcd_rect_write_sequencer.sv =====
// Top level of the rectangle write sequencer for a two-controller 480-column panel.
// Depends on dlrws_pkg, dlrws_tracker and dlrws_emitter.
//
// Input channel s_*: one bitmap byte per transfer, row-major over the rectangle.
// Output channel m_*: controller bytes with the command/data level, a flag on
// the final byte of each input's run and a flag on the rectangle's last byte.
// Configuration: cfg_wr_en/cfg_index/cfg_wdata write a register;
// writing a geometry register puts the position back to the rectangle's start.
// Each input gives 1 byte, or 9 or 17 when one or two addressing runs (row
// start, split column) come first. The output stage emits one byte per cycle
// while m_ready is high, and plain data bytes stream at one per cycle as well.
// An input transfer passes the job register, then the output register, on
// its way to its first output byte.
// Reset clears both channels and loads the register reset values, position at
// the start corner. When the receiver stalls the output byte holds, the job
// register keeps its pending byte, and s_ready stays low until the job's data
// byte moves into the output register.
module dual_lcd_rect_write_sequencer import dlrws_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [COL_W-1:0]  cfg_wdata,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_pixel_byte,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_bus_byte,
    output logic              m_is_data,
    output logic              m_last_of_run,
    output logic              m_image_done
);

    plan_t plan;
    logic  accept;

    assign accept = s_valid && s_ready;

    dlrws_tracker u_tracker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .accept     (accept),
        .pixel_byte (s_pixel_byte),
        .plan       (plan)
    );

    dlrws_emitter u_emitter (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (accept),
        .plan          (plan),
        .in_ready      (s_ready),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_bus_byte    (m_bus_byte),
        .m_is_data     (m_is_data),
        .m_last_of_run (m_last_of_run),
        .m_image_done  (m_image_done)
    );

endmodule

// ===== rtl/dlrws_checker.sv =====
// Port-level checks for the rectangle write sequencer, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module dlrws_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_bus_byte,
    input logic       m_is_data,
    input logic       m_last_of_run,
    input logic       m_image_done
);

    logic [10:0] out_word;

    assign out_word = {m_bus_byte, m_is_data, m_last_of_run, m_image_done};

    property p_stall_hold;
        m_valid && !m_ready |=> m_valid && $stable(out_word);
    endproperty

    property p_done_on_last;
        m_valid && m_image_done |-> m_last_of_run;
    endproperty

    property p_last_is_data;
        m_valid && m_last_of_run |-> m_is_data;
    endproperty

    property p_reset_clears;
        !aresetn |=> !m_valid;
    endproperty

    `ASSERT_RST(a_stall_hold, aclk, aresetn, p_stall_hold, "output changed under stall")
    `ASSERT_RST(a_done_on_last, aclk, aresetn, p_done_on_last, "image end off the final byte")
    `ASSERT_RST(a_last_is_data, aclk, aresetn, p_last_is_data, "final byte is not data")
    `ASSERT_ANY(a_reset_clears, aclk, p_reset_clears, "output valid after reset")

endmodule

bind dual_lcd_rect_write_sequencer dlrws_checker u_dlrws_checker (.*);

// ===== dv/dual_lcd_rect_write_sequencer_test.sv =====
// Self-checking test of the dual-controller rectangle write sequencer.
// Predicts the controller byte stream for every pixel transfer and checks it in order.
// Depends on dlrws_pkg and dual_lcd_rect_write_sequencer.
`timescale 1ns / 1ps

module dual_lcd_rect_write_sequencer_test;
    import dlrws_pkg::*;

    typedef struct packed {
        logic [7:0] bus_byte;
        logic       is_data;
        logic       last_of_run;
        logic       image_done;
    } bus_word_t;

    logic              aclk;
    logic              aresetn;
    logic              cfg_wr_en;
    logic [IDX_W-1:0]  cfg_index;
    logic [COL_W-1:0]  cfg_wdata;
    logic              s_valid;
    logic              s_ready;
    logic [7:0]        s_pixel_byte;
    logic              m_valid;
    logic              m_ready;
    logic [7:0]        m_bus_byte;
    logic              m_is_data;
    logic              m_last_of_run;
    logic              m_image_done;

    // Mirror of the block's registers and write position
    logic [COL_W-1:0]  mdl_start_col;
    logic [COL_W-1:0]  mdl_end_col;
    logic [PAGE_W-1:0] mdl_start_page;
    logic [PAGE_W-1:0] mdl_end_page;
    logic              mdl_invert;
    logic [COL_W-1:0]  pos_col;
    logic [PAGE_W-1:0] pos_page;

    bus_word_t expected_bus[$];

    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int hold_cycles = 0;
    int n_errors = 0;
    int n_pixels = 0;
    int n_checked = 0;
    int n_images = 0;
    int n_double_runs = 0;

    dual_lcd_rect_write_sequencer u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel_byte  (s_pixel_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_bus_byte    (m_bus_byte),
        .m_is_data     (m_is_data),
        .m_last_of_run (m_last_of_run),
        .m_image_done  (m_image_done)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #3_000_000;
        $display("Timeout: %0d bus bytes still outstanding", expected_bus.size());
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction

    function automatic void push_word(logic [7:0] b, logic d, logic l, logic dn);
        bus_word_t w;
        w.bus_byte    = b;
        w.is_data     = d;
        w.last_of_run = l;
        w.image_done  = dn;
        expected_bus.push_back(w);
    endfunction

    function automatic void push_addressing(logic [COL_W-1:0] col, logic [PAGE_W-1:0] page);
        logic             left;
        logic [COL_W-1:0] seg;
        left = col < SPLIT_COLUMN;
        seg  = left ? col + SEG_OFFSET : col - SPLIT_COLUMN + SEG_OFFSET;
        push_word(left ? CMD_SEL_LEFT : CMD_SEL_RIGHT, 1'b0, 1'b0, 1'b0);
        push_word(CMD_PAGE_SET, 1'b0, 1'b0, 1'b0);
        push_word(PAGE_OFFSET + 8'(page), 1'b1, 1'b0, 1'b0);
        push_word(PAR_PAGE_END, 1'b1, 1'b0, 1'b0);
        push_word(CMD_COL_SET, 1'b0, 1'b0, 1'b0);
        push_word(seg[7:0], 1'b1, 1'b0, 1'b0);
        push_word(PAR_COL_END, 1'b1, 1'b0, 1'b0);
        push_word(CMD_WRITE, 1'b0, 1'b0, 1'b0);
    endfunction

    function automatic void predict_bus_bytes(logic [7:0] pix);
        logic row_end;
        logic img_end;
        int   n_before;
        row_end  = pos_col >= mdl_end_col;
        img_end  = row_end && (pos_page >= mdl_end_page);
        n_before = expected_bus.size();
        if (pos_col == mdl_start_col)
            push_addressing(pos_col, pos_page);
        if (pos_col == SPLIT_COLUMN)
            push_addressing(pos_col, pos_page);
        push_word(mdl_invert ? ~pix : pix, 1'b1, 1'b1, img_end);
        if (expected_bus.size() - n_before == 17)
            n_double_runs++;
        if (img_end) begin
            pos_col  = mdl_start_col;
            pos_page = mdl_start_page;
        end else if (row_end) begin
            pos_col  = mdl_start_col;
            pos_page = pos_page + 1'b1;
        end else begin
            pos_col = pos_col + 1'b1;
        end
    endfunction

    function automatic void apply_reg_write(logic [IDX_W-1:0] idx, logic [COL_W-1:0] data);
        case (idx)
            REG_START_COLUMN: mdl_start_col  = data;
            REG_END_COLUMN:   mdl_end_col    = data;
            REG_START_PAGE:   mdl_start_page = data[PAGE_W-1:0];
            REG_END_PAGE:     mdl_end_page   = data[PAGE_W-1:0];
            REG_INVERT:       mdl_invert     = data[0];
            default: ;
        endcase
        if (idx inside {REG_START_COLUMN, REG_END_COLUMN, REG_START_PAGE, REG_END_PAGE}) begin
            pos_col  = mdl_start_col;
            pos_page = mdl_start_page;
        end
    endfunction

    // ------------------------------------------------------------------
    // Result checking

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t ns: mismatch on %s: got %02h, expected %02h", $time, what, got, want);
        n_errors++;
    endtask

    always @(posedge aclk) begin
        bus_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_bus.size() == 0) begin
                report_mismatch("unexpected bus byte", m_bus_byte, 0);
            end else begin
                want = expected_bus.pop_front();
                n_checked++;
                if (m_bus_byte !== want.bus_byte)
                    report_mismatch("bus_byte", m_bus_byte, want.bus_byte);
                if (m_is_data !== want.is_data)
                    report_mismatch("is_data", m_is_data, want.is_data);
                if (m_last_of_run !== want.last_of_run)
                    report_mismatch("last_of_run", m_last_of_run, want.last_of_run);
                if (m_image_done !== want.image_done)
                    report_mismatch("image_done", m_image_done, want.image_done);
                if (want.image_done)
                    n_images++;
            end
        end
    end

    // Receiver: long hold when asked, otherwise random stalls
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_ready = 1'b0;
                hold_cycles--;
            end else begin
                m_ready = ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers

    task automatic send_pixel(logic [7:0] pix);
        while ($urandom_range(99) < sender_idle_pct) begin
            @(negedge aclk);
            s_valid = 1'b0;
        end
        @(negedge aclk);
        s_valid      = 1'b1;
        s_pixel_byte = pix;
        do @(posedge aclk); while (!s_ready);
        n_pixels++;
        predict_bus_bytes(pix);
    endtask

    // Drop valid and let the pipeline drain before touching registers
    task automatic wait_idle();
        @(negedge aclk);
        s_valid = 1'b0;
        while (expected_bus.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [COL_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        @(posedge aclk);
        apply_reg_write(idx, data);
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic set_rectangle(logic [COL_W-1:0] sc, logic [COL_W-1:0] ec,
                                 logic [COL_W-1:0] sp, logic [COL_W-1:0] ep);
        write_reg(REG_START_COLUMN, sc);
        write_reg(REG_END_COLUMN, ec);
        write_reg(REG_START_PAGE, sp);
        write_reg(REG_END_PAGE, ep);
    endtask

    // ------------------------------------------------------------------
    // Tests

    task automatic test_reset_corner();
        send_pixel(8'h00);
        send_pixel(8'hFF);
        send_pixel(8'hA5);
        wait_idle();
    endtask

    // Rows crossing the split, a row starting on it, and invert on and off
    task automatic test_split_and_invert();
        set_rectangle(9'd238, 9'd241, 9'd2, 9'd3);
        write_reg(REG_INVERT, 9'd1);
        for (int i = 0; i < 8; i++)
            send_pixel(8'(i * 37));
        wait_idle();
        write_reg(REG_START_COLUMN, SPLIT_COLUMN);
        send_pixel(8'h0F);
        wait_idle();
        // invert write keeps the position mid-row
        write_reg(REG_INVERT, 9'd0);
        send_pixel(8'hF0);
        wait_idle();
        // writes to unused indexes are dropped
        for (int i = REG_INVERT + 1; i < (1 << IDX_W); i++)
            write_reg(IDX_W'(i), 9'h1FF);
        send_pixel(8'h5A);
        wait_idle();
    endtask

    task automatic test_start_beyond_end();
        set_rectangle(9'd300, 9'd10, 9'd5, 9'd1);
        send_pixel(8'h81);
        send_pixel(8'h7E);
        send_pixel(8'h01);
        wait_idle();
    endtask

    task automatic test_out_of_range();
        set_rectangle(9'h1FF, 9'h1FF, 9'd15, 9'd15);
        send_pixel(8'hC3);
        send_pixel(8'h3C);
        wait_idle();
    endtask

    // Geometry write mid-row puts the position back to the start corner
    task automatic test_geometry_reload();
        set_rectangle(9'd0, 9'd3, 9'd0, 9'd0);
        send_pixel(8'h11);
        send_pixel(8'h22);
        wait_idle();
        write_reg(REG_END_COLUMN, 9'd5);
        send_pixel(8'h33);
        wait_idle();
    endtask

    task automatic test_random_images(int n_items);
        logic [COL_W-1:0] sc;
        logic [COL_W-1:0] ec;
        logic [COL_W-1:0] sp;
        logic [COL_W-1:0] ep;
        int               cols;
        int               pages;
        int               total;
        int               sent;
        sent = 0;
        while (sent < n_items) begin
            case ($urandom_range(3))
                0:       sc = COL_W'($urandom_range(20));
                1:       sc = COL_W'($urandom_range(245, 232));
                2:       sc = COL_W'($urandom_range(511));
                default: sc = COL_W'($urandom_range(479, 460));
            endcase
            ec = ($urandom_range(7) == 0) ? COL_W'($urandom_range(511))
                                          : sc + COL_W'($urandom_range(9));
            sp = ($urandom_range(7) == 0) ? COL_W'($urandom_range(15))
                                          : COL_W'($urandom_range(11));
            ep = ($urandom_range(7) == 0) ? COL_W'($urandom_range(15))
                                          : sp + COL_W'($urandom_range(2));
            ep = ep & 9'h00F;
            set_rectangle(sc, ec, sp, ep);
            if ($urandom_range(3) == 0)
                write_reg(REG_INVERT, COL_W'($urandom_range(1)));
            cols  = (ec >= sc) ? int'(ec) - int'(sc) + 1 : 1;
            pages = (ep >= sp) ? int'(ep) - int'(sp) + 1 : 1;
            total = cols * pages;
            // cut long images short, and now and then break one off early
            if (total > 40 || $urandom_range(5) == 0)
                total = $urandom_range((total > 40) ? 40 : total, 1);
            repeat (total)
                send_pixel(8'($urandom_range(255)));
            sent += total;
            wait_idle();
        end
    endtask

    // Receiver holds off while the sender keeps offering transfers
    task automatic test_backpressure();
        set_rectangle(9'd232, 9'd247, 9'd0, 9'd1);
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        @(posedge aclk);
        hold_cycles = 400;
        for (int i = 0; i < 40; i++)
            send_pixel(8'($urandom_range(255)));
        wait_idle();
    endtask

    initial begin
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = REG_START_COLUMN;
        cfg_wdata    = '0;
        s_valid      = 1'b0;
        s_pixel_byte = '0;
        mdl_start_col  = RST_START_COLUMN;
        mdl_end_col    = RST_END_COLUMN;
        mdl_start_page = RST_START_PAGE;
        mdl_end_page   = RST_END_PAGE;
        mdl_invert     = 1'b0;
        pos_col        = RST_START_COLUMN;
        pos_page       = RST_START_PAGE;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_corner();
        test_split_and_invert();
        test_start_beyond_end();
        test_out_of_range();
        test_geometry_reload();

        sender_idle_pct = 0;  receiver_stall_pct = 0;
        test_random_images(60);
        sender_idle_pct = 53; receiver_stall_pct = 0;
        test_random_images(60);
        sender_idle_pct = 0;  receiver_stall_pct = 53;
        test_random_images(60);
        sender_idle_pct = 20; receiver_stall_pct = 20;
        test_random_images(60);

        test_backpressure();

        wait_idle();
        repeat (20) @(posedge aclk);
        $display("Sent %0d pixel transfers and checked %0d bus bytes over %0d finished images;",
                 n_pixels, n_checked, n_images);
        $display("%0d transfers carried both the row-start and split addressing sequences.",
                 n_double_runs);
        if (n_errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
